// ===== rtl/ultrasonic_echo_ranger_filter_macros.svh =====
// Assertion macros for the ultrasonic echo ranger filter.
// Expects signals named clock and reset in the scope that uses them.
`ifndef ULTRASONIC_ECHO_RANGER_FILTER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_FILTER_MACROS_SVH

// same-cycle implication
`define UERF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ranger filter check failed");

// next-cycle implication
`define UERF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ranger filter check failed");

`endif

// ===== rtl/uerf_pkg.sv =====
// Types and constants shared by the ultrasonic echo ranger filter.
// No dependencies.
package uerf_pkg;

   localparam int DIST_W     = 13;  // distance in 1/16 cm
   localparam int TICK_W     = 24;  // tick counter
   localparam int LIMIT_W    = 15;  // fall limit, at most 30058 ticks
   localparam int PROD_W     = 25;  // tick count times RAW_STEP while high
   localparam int RANGE_W    = 9;   // range registers in cm
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // width to distance: (ticks * 1114) >> 12
   localparam logic [PROD_W-1:0] RAW_STEP  = 25'd1114;
   localparam int                RAW_SHIFT = 12;

   // fall limit = floor(range_cm * 58.8235) = (range_cm * FALL_RECIP) >> FALL_SHIFT,
   // exact for every 9-bit range
   localparam int                FALL_PROD_W = 35;
   localparam logic [25:0]       FALL_RECIP  = 26'd61680911;
   localparam int                FALL_SHIFT  = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ECHO   = 2'd2;

   // reset values
   localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 9'd3;
   localparam logic [LIMIT_W-1:0] FALL_LIMIT_RST = 15'd23529;  // 400 cm
   localparam logic [TICK_W-1:0]  NO_ECHO_RST   = 24'd30000;

   // request command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic cmd;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] filtered_distance;
      logic [DIST_W-1:0] raw_distance;
      logic              timed_out;
      logic              filter_ready;
   } rsp_type;

endpackage

// ===== rtl/uerf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module uerf_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/ultrasonic_echo_ranger_filter.sv =====
// Ultrasonic echo ranger with moving-average filter. Each request is a 1 us tick
// carrying the echo pin level, or a start command (cmd = 1). After a start the
// block waits up to no_echo_ticks low ticks for the echo to rise (else it returns
// a timed_out result), then counts high ticks until the fall or until
// floor(58.8235 * max_range_cm) ticks. The width becomes (W * 1114) >> 12 in
// 1/16 cm, raised to min_range_cm * 16, and feeds a WINDOW-deep moving average.
// Rate: one request per clock while req_ready is high. A result is in the output
// register in the cycle after the request that ends a measurement. req_ready drops
// only while a result waits in the output register and rsp_ready is low. The sample
// ring lives in a RAM read ahead at the next ring pointer, so the oldest sample is
// already in the read register when a measurement ends. Results are only produced
// by ends two or more requests apart, so ring reads and writes never hit the same
// entry. The ring needs no clearing pass: it is read only after warm-up has written
// every entry. Register writes take effect on the next request.
// Depends on uerf_pkg, uerf_ram and the assertion macro header.
`include "ultrasonic_echo_ranger_filter_macros.svh"

module ultrasonic_echo_ranger_filter #(
   parameter int WINDOW = 8   // 2 to 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  uerf_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output uerf_pkg::rsp_type                 rsp_data,
   // register writes
   input  logic                              csr_write_en,
   input  logic [uerf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [uerf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = uerf_pkg::DIST_W + $clog2(WINDOW);
   // sum / WINDOW as multiply by ceil(2^SH / WINDOW), exact for any SUM_W-bit sum
   localparam int AVG_SH = SUM_W + $clog2(WINDOW);
   localparam int AVG_W  = 2 * SUM_W + 1;
   localparam logic [AVG_SH:0] RECIP_FULL =
      (((AVG_SH + 1)'(1) << AVG_SH) + (AVG_SH + 1)'(WINDOW - 1)) / (AVG_SH + 1)'(WINDOW);
   localparam logic [SUM_W:0] AVG_RECIP = RECIP_FULL[SUM_W:0];

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH
   } phase_type;

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   phase_type                           phase_ff, phase_in;
   logic [uerf_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [uerf_pkg::PROD_W-1:0]         prod_ff, prod_in;     // tick * 1114 while high
   logic [PTR_W-1:0]                    ptr_ff, ptr_in;
   logic [FILL_W-1:0]                   fill_count_ff, fill_count_in;
   logic [SUM_W-1:0]                    running_sum_ff, running_sum_in;

   // registers
   logic [uerf_pkg::RANGE_W-1:0]        min_range_ff, min_range_in;
   logic [uerf_pkg::LIMIT_W-1:0]        fall_limit_ff, fall_limit_in;
   logic [uerf_pkg::TICK_W-1:0]         no_echo_ff, no_echo_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [uerf_pkg::DIST_W-1:0]         raw_ff, raw_in;
   logic                                timed_out_ff, timed_out_in;
   logic                                filter_ready_ff, filter_ready_in;

   // ring RAM
   logic                                ring_we;
   logic [uerf_pkg::DIST_W-1:0]         ring_oldest;

   logic                                accept;
   logic                                finish;
   logic                                timeout;
   logic [uerf_pkg::PROD_W-1:0]         prod_fin;
   logic [uerf_pkg::TICK_W-1:0]         tick_inc;
   logic [uerf_pkg::TICK_W-1:0]         limit_ext;
   logic [uerf_pkg::DIST_W-1:0]         raw_scaled;
   logic [uerf_pkg::DIST_W-1:0]         floor16;
   logic [uerf_pkg::DIST_W-1:0]         raw_dist;
   logic [uerf_pkg::FALL_PROD_W-1:0]    fall_product;
   logic [AVG_W-1:0]                    avg_product;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign tick_inc   = tick_ff + uerf_pkg::TICK_W'(1);
   assign limit_ext  = uerf_pkg::TICK_W'(fall_limit_ff);
   assign floor16    = {min_range_ff, 4'd0};
   assign fall_product = uerf_pkg::FALL_PROD_W'(csr_wdata[uerf_pkg::RANGE_W-1:0])
                       * uerf_pkg::FALL_PROD_W'(uerf_pkg::FALL_RECIP);

   // ---------------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------------
   always_comb begin
      min_range_in  = min_range_ff;
      fall_limit_in = fall_limit_ff;
      no_echo_in    = no_echo_ff;
      if (csr_write_en) begin
         case (csr_index)
            uerf_pkg::CSR_MIN_RANGE: min_range_in = csr_wdata[uerf_pkg::RANGE_W-1:0];
            uerf_pkg::CSR_MAX_RANGE:
               fall_limit_in = fall_product[uerf_pkg::FALL_SHIFT +: uerf_pkg::LIMIT_W];
            uerf_pkg::CSR_NO_ECHO:   no_echo_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // measurement sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      prod_in  = prod_ff;
      finish   = 1'b0;
      timeout  = 1'b0;
      prod_fin = prod_ff;
      if (accept) begin
         if (req_data.cmd == uerf_pkg::CMD_START) begin
            phase_in = PH_WAIT;
            tick_in  = '0;
            prod_in  = '0;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  if (req_data.echo_level) begin
                     // rise tick is the first high tick
                     phase_in = PH_HIGH;
                     tick_in  = uerf_pkg::TICK_W'(1);
                     prod_in  = uerf_pkg::RAW_STEP;
                     prod_fin = uerf_pkg::RAW_STEP;
                     finish   = (uerf_pkg::LIMIT_W'(1) >= fall_limit_ff);
                  end else if (tick_inc >= no_echo_ff) begin
                     timeout = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               PH_HIGH: begin
                  if (!req_data.echo_level) begin
                     finish = 1'b1;
                  end else begin
                     tick_in  = tick_inc;
                     prod_in  = prod_ff + uerf_pkg::RAW_STEP;
                     prod_fin = prod_ff + uerf_pkg::RAW_STEP;
                     finish   = (tick_inc >= limit_ext);
                  end
               end
               default: ;
            endcase
         end
         if (finish || timeout) begin
            phase_in = PH_IDLE;
            tick_in  = '0;
            prod_in  = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // filter update: read-modify-write of the ring entry at the pointer
   // ---------------------------------------------------------------------
   assign raw_scaled = prod_fin[uerf_pkg::PROD_W-1:uerf_pkg::RAW_SHIFT];
   assign raw_dist   = (raw_scaled < floor16) ? floor16 : raw_scaled;
   assign ring_we    = finish;

   always_comb begin
      ptr_in          = ptr_ff;
      fill_count_in   = fill_count_ff;
      running_sum_in  = running_sum_ff;
      filter_ready_in = filter_ready_ff;
      if (finish) begin
         if (fill_count_ff < FILL_W'(WINDOW)) begin
            // warm-up: store every sample
            running_sum_in  = running_sum_ff + SUM_W'(raw_dist);
            fill_count_in   = fill_count_ff + FILL_W'(1);
            filter_ready_in = 1'b0;
         end else begin
            running_sum_in  = running_sum_ff - SUM_W'(ring_oldest) + SUM_W'(raw_dist);
            filter_ready_in = 1'b1;
         end
         ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
      end else if (timeout) begin
         filter_ready_in = 1'b0;
      end
   end

   uerf_ram #(
      .WIDTH (uerf_pkg::DIST_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ptr_ff),
      .wr_data (raw_dist),
      .rd_addr (ptr_in),     // read ahead: next oldest sample
      .rd_data (ring_oldest)
   );

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      raw_in       = raw_ff;
      timed_out_in = timed_out_ff;
      if (finish || timeout) begin
         rsp_valid_in = 1'b1;
         raw_in       = timeout ? '0 : raw_dist;
         timed_out_in = timeout;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // running sum holds still while a result waits, so the average is taken here
   assign avg_product = AVG_W'(running_sum_ff) * AVG_W'(AVG_RECIP);

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_data.raw_distance      = raw_ff;
   assign rsp_data.timed_out         = timed_out_ff;
   assign rsp_data.filter_ready      = filter_ready_ff;
   assign rsp_data.filtered_distance =
      filter_ready_ff ? avg_product[AVG_SH +: uerf_pkg::DIST_W] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_ff        <= '0;
         prod_ff        <= '0;
         ptr_ff         <= '0;
         fill_count_ff  <= '0;
         running_sum_ff <= '0;
         min_range_ff   <= uerf_pkg::MIN_RANGE_RST;
         fall_limit_ff  <= uerf_pkg::FALL_LIMIT_RST;
         no_echo_ff     <= uerf_pkg::NO_ECHO_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         tick_ff        <= tick_in;
         prod_ff        <= prod_in;
         ptr_ff         <= ptr_in;
         fill_count_ff  <= fill_count_in;
         running_sum_ff <= running_sum_in;
         min_range_ff   <= min_range_in;
         fall_limit_ff  <= fall_limit_in;
         no_echo_ff     <= no_echo_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      raw_ff          <= raw_in;
      timed_out_ff    <= timed_out_in;
      filter_ready_ff <= filter_ready_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `UERF_ASSERT_NOW(a_timeout_zero, rsp_valid_ff && timed_out_ff, (raw_ff == '0) && !filter_ready_ff && (rsp_data.filtered_distance == '0))
   `UERF_ASSERT_NOW(a_ready_full, rsp_valid_ff && filter_ready_ff, fill_count_ff == FILL_W'(WINDOW))
   `UERF_ASSERT_NOW(a_raw_floor, rsp_valid_ff && !timed_out_ff, raw_ff >= floor16)
   `UERF_ASSERT_NEXT(a_idle_silent, accept && (req_data.cmd == uerf_pkg::CMD_TICK) && (phase_ff == PH_IDLE), !rsp_valid_ff)

endmodule

// ===== tb/sv/ultrasonic_echo_ranger_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ultrasonic echo ranger filter: a queue-fed request
// driver, a result monitor with its own distance and moving-average predictor.
// Depends on uerf_pkg and the ultrasonic_echo_ranger_filter RTL.
module ultrasonic_echo_ranger_filter_tb;

   localparam int WINDOW       = 8;
   localparam int RANDOM_ITEMS = 600;
   localparam int PHASE_ITEMS  = 200;
   localparam int SETTLE       = 6;    // result lands in the cycle after its request
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 2000000;

   // index past the register list, must be ignored
   localparam logic [uerf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {RANGE_IDLE, RANGE_WAIT, RANGE_HIGH} range_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   uerf_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b1;
   uerf_pkg::rsp_type               rsp_data;
   logic                            csr_write_en = 1'b0;
   logic [uerf_pkg::CSR_IDX_W-1:0]  csr_index = uerf_pkg::CSR_MIN_RANGE;
   logic [uerf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ultrasonic_echo_ranger_filter #(.WINDOW(WINDOW)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: measurement tracker, sample ring and register copies
   // ---------------------------------------------------------------------
   range_phase_type  rg_phase;
   logic [23:0]      rg_ticks;
   logic [12:0]      rg_ring [WINDOW];
   int               rg_ptr;
   int               rg_fill;
   int unsigned      rg_sum;
   logic [8:0]       rg_min;
   logic [8:0]       rg_max;
   logic [23:0]      rg_no_echo;

   uerf_pkg::req_type tick_stream [$];       // requests waiting for the driver
   uerf_pkg::rsp_type pending_readings [$];  // predicted results not yet seen

   int  ticks_sent     = 0;        // requests put on the bus
   int  ticks_taken    = 0;        // requests accepted by the block
   int  mismatches     = 0;
   int  items_queued   = 0;
   int  cycles_run     = 0;
   bit  calm           = 1'b0;     // no idling on either side
   bit  long_hold_armed = 1'b0;

   // fall timeout in ticks: floor(cm * 58.8235)
   function automatic int unsigned fall_limit(input logic [8:0] cm);
      return (int'(cm) * 588235) / 10000;
   endfunction

   task automatic ranger_reset();
      rg_phase   = RANGE_IDLE;
      rg_ticks   = '0;
      rg_ptr     = 0;
      rg_fill    = 0;
      rg_sum     = 0;
      rg_min     = uerf_pkg::MIN_RANGE_RST;
      rg_max     = 9'd400;
      rg_no_echo = uerf_pkg::NO_ECHO_RST;
   endtask

   // end of a pulse: convert, clamp, update the average, queue the reading
   task automatic record_distance();
      int unsigned       reading;
      int unsigned       floor16;
      uerf_pkg::rsp_type r;
      reading = (int'(rg_ticks) * 1114) >> 12;
      floor16 = int'(rg_min) * 16;
      if (reading < floor16) reading = floor16;
      r = '0;
      r.raw_distance = reading[12:0];
      if (rg_fill < WINDOW) begin
         // warm-up: store only, no average yet
         rg_ring[rg_ptr] = reading[12:0];
         rg_sum += reading[12:0];
         rg_fill++;
      end else begin
         rg_sum = rg_sum - rg_ring[rg_ptr] + reading[12:0];
         rg_ring[rg_ptr] = reading[12:0];
         r.filtered_distance = 13'(rg_sum / WINDOW);
         r.filter_ready = 1'b1;
      end
      rg_ptr   = (rg_ptr + 1) % WINDOW;
      rg_phase = RANGE_IDLE;
      rg_ticks = '0;
      pending_readings.push_back(r);
   endtask

   task automatic predict_reading(input uerf_pkg::req_type rq);
      uerf_pkg::rsp_type r;
      if (rq.cmd == uerf_pkg::CMD_START) begin
         // restart in any phase, echo level ignored
         rg_phase = RANGE_WAIT;
         rg_ticks = '0;
      end else begin
         case (rg_phase)
            RANGE_WAIT: begin
               if (rq.echo_level) begin
                  // rise tick counts as the first high tick
                  rg_phase = RANGE_HIGH;
                  rg_ticks = 24'd1;
                  if (rg_ticks >= fall_limit(rg_max)) record_distance();
               end else begin
                  rg_ticks = rg_ticks + 24'd1;
                  if (rg_ticks >= rg_no_echo) begin
                     rg_phase = RANGE_IDLE;
                     rg_ticks = '0;
                     r = '0;
                     r.timed_out = 1'b1;
                     pending_readings.push_back(r);
                  end
               end
            end
            RANGE_HIGH: begin
               if (!rq.echo_level) begin
                  record_distance();
               end else begin
                  rg_ticks = rg_ticks + 24'd1;
                  if (rg_ticks >= fall_limit(rg_max)) record_distance();
               end
            end
            default: rg_phase = RANGE_IDLE;  // ticks while idle do nothing
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: one request at a time from tick_stream, random gaps
   // ---------------------------------------------------------------------
   int gap_left = 0;

   always @(negedge clock) begin
      bit                next_valid;
      uerf_pkg::req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && ticks_taken != ticks_sent)) begin
         // nothing on the bus, or the last request was taken
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (tick_stream.size() == 0) begin
            next_valid = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 9);  // start a burst of idle cycles
         end else begin
            next_req   = tick_stream.pop_front();
            next_valid = 1'b1;
            ticks_sent++;
            req_data <= next_req;
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: random stalls plus one long hold-off
   // ---------------------------------------------------------------------
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;

   always @(negedge clock) begin
      bit take;
      take = 1'b1;
      if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else if (long_hold_armed && !long_hold_done) begin
         // long hold: the output register fills and the block backs up
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD - 1;
         take = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         take = 1'b0;
      end
      rsp_ready <= take;
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on accepted requests, check accepted results
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      uerf_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_reading(req_data);
            ticks_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $error("unexpected result: filtered %0d raw %0d timed_out %0d ready %0d",
                      rsp_data.filtered_distance, rsp_data.raw_distance,
                      rsp_data.timed_out, rsp_data.filter_ready);
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               if (rsp_data.filtered_distance !== want.filtered_distance) begin
                  $error("filtered_distance: expected %0d, actual %0d",
                         want.filtered_distance, rsp_data.filtered_distance);
                  mismatches++;
               end
               if (rsp_data.raw_distance !== want.raw_distance) begin
                  $error("raw_distance: expected %0d, actual %0d",
                         want.raw_distance, rsp_data.raw_distance);
                  mismatches++;
               end
               if (rsp_data.timed_out !== want.timed_out) begin
                  $error("timed_out: expected %0d, actual %0d",
                         want.timed_out, rsp_data.timed_out);
                  mismatches++;
               end
               if (rsp_data.filter_ready !== want.filter_ready) begin
                  $error("filter_ready: expected %0d, actual %0d",
                         want.filter_ready, rsp_data.filter_ready);
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_item(input logic cmd, input logic echo);
      uerf_pkg::req_type rq;
      rq.cmd = cmd;
      rq.echo_level = echo;
      tick_stream.push_back(rq);
      items_queued++;
   endtask

   task automatic push_ticks(input int count, input logic echo);
      repeat (count) push_item(uerf_pkg::CMD_TICK, echo);
   endtask

   // register write, one per cycle; predictor copy follows at once
   task automatic write_reg(input logic [uerf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [uerf_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         uerf_pkg::CSR_MIN_RANGE: rg_min     = val[8:0];
         uerf_pkg::CSR_MAX_RANGE: rg_max     = val[8:0];
         uerf_pkg::CSR_NO_ECHO:   rg_no_echo = val[23:0];
         default: ;
      endcase
   endtask

   task automatic program_ranger(input int min_cm, input int max_cm, input int no_echo);
      write_reg(uerf_pkg::CSR_MIN_RANGE, uerf_pkg::CSR_DATA_W'(min_cm));
      write_reg(uerf_pkg::CSR_MAX_RANGE, uerf_pkg::CSR_DATA_W'(max_cm));
      write_reg(uerf_pkg::CSR_NO_ECHO, uerf_pkg::CSR_DATA_W'(no_echo));
      write_reg(CSR_UNUSED, uerf_pkg::CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // sender holds off until every predicted result is in, then a short pause
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_stream.size() != 0 || ticks_taken != ticks_sent ||
             pending_readings.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // mostly well-formed measurements with random lengths, some noise
   task automatic add_random_sequence();
      int kind;
      int lim;
      int cap_lows;
      int cap_highs;
      kind = $urandom_range(0, 9);
      lim  = fall_limit(rg_max);
      if (kind == 0) begin
         repeat ($urandom_range(1, 6))
            push_item($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
      end else begin
         if (kind == 1) begin
            // abandoned measurement, restarted by the next start
            push_item(uerf_pkg::CMD_START, 1'($urandom_range(0, 1)));
            push_ticks($urandom_range(0, 3), 1'($urandom_range(0, 1)));
         end
         cap_lows  = (rg_no_echo > 40) ? 40 : int'(rg_no_echo);
         cap_highs = (lim + 1 > 40) ? 40 : lim + 1;
         if ($urandom_range(0, 19) == 0) cap_highs = lim + 1;  // run to the fall limit
         push_item(uerf_pkg::CMD_START, 1'($urandom_range(0, 1)));
         push_ticks($urandom_range(0, cap_lows + 1), 1'b0);
         push_ticks($urandom_range(1, cap_highs), 1'b1);
         push_item(uerf_pkg::CMD_TICK, 1'b0);
         if (kind == 2) push_item(uerf_pkg::CMD_TICK, 1'($urandom_range(0, 1)));  // idle tick
      end
   endtask

   task automatic program_random();
      int min_cm;
      int max_cm;
      int no_echo;
      min_cm  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 12);
      max_cm  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      no_echo = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 24'hFFFFFF)
                                            : $urandom_range(0, 30);
      program_ranger(min_cm, max_cm, no_echo);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int rand_items0;
      int phase_items0;
      ranger_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: idle ticks ignored, short pulse clamped to the floor,
      // start repeated, then a longer pulse well inside the 400 cm fall limit
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      push_item(uerf_pkg::CMD_TICK, 1'b1);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(2, 1'b0);
      push_ticks(5, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      push_item(uerf_pkg::CMD_START, 1'b1);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(120, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      wait_drained();

      // tight settings: one-tick rise timeout, fall limit of 176 ticks,
      // restart in the middle of a pulse, single-tick pulse
      program_ranger(2, 3, 1);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(fall_limit(9'd3), 1'b1);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(3, 1'b1);
      push_item(uerf_pkg::CMD_START, 1'b1);
      push_ticks(2, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_item(uerf_pkg::CMD_TICK, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      wait_drained();

      // all zero: first low tick times out, rise tick ends the pulse
      program_ranger(0, 0, 0);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_item(uerf_pkg::CMD_TICK, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      wait_drained();

      // all ones: largest floor, pulse well inside the longest fall limit
      program_ranger(511, 511, 24'hFFFFFF);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(3, 1'b0);
      push_item(uerf_pkg::CMD_START, 1'b0);
      push_ticks(40, 1'b1);
      push_item(uerf_pkg::CMD_TICK, 1'b0);
      wait_drained();

      // random phases, each with fresh settings
      rand_items0 = items_queued;
      while (items_queued - rand_items0 < RANDOM_ITEMS) begin
         program_random();
         phase_items0 = items_queued;
         while (items_queued - phase_items0 < PHASE_ITEMS) add_random_sequence();
         long_hold_armed = 1'b1;
         wait_drained();
      end

      // last stretch at full rate on both sides
      calm = 1'b1;
      program_random();
      phase_items0 = items_queued;
      while (items_queued - phase_items0 < PHASE_ITEMS) add_random_sequence();
      wait_drained();

      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
